// ===== rtl/core/rational_arithmetic_unit_macros.svh =====
// assertion helpers used by the rtl controller
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau assertion failed");
`define RAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau assertion failed");
`else
`define RAU_ASSERT_IMP(label, ante, cons)
`define RAU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

    localparam int RES_W  = 34;
    localparam int ACT_W  = 2;
    localparam int OUT_DW = ((2 * RES_W + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MUL = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DIV = 2'd3;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
    localparam logic [OP_W-1:0] OP_MUL_A      = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL_B      = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_C      = 4'd3;
    localparam logic [OP_W-1:0] OP_DEN        = 4'd4;
    localparam logic [OP_W-1:0] OP_GCD_INIT   = 4'd5;
    localparam logic [OP_W-1:0] OP_TWOS       = 4'd6;
    localparam logic [OP_W-1:0] OP_MAKE_ODD   = 4'd7;
    localparam logic [OP_W-1:0] OP_GCD_STEP   = 4'd8;
    localparam logic [OP_W-1:0] OP_DIV_N_INIT = 4'd9;
    localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd10;
    localparam logic [OP_W-1:0] OP_DIV_D_INIT = 4'd11;

    typedef struct packed {
        logic            capture;
        logic            load_out;
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic num_zero;
        logic both_even;
        logic v_zero;
        logic div_done;
    } dp_stat_t;

endpackage

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: one input beat carries two signed fractions and an operation
// (add, subtract, multiply, divide); one output beat returns the result reduced by the
// greatest common divisor, denominator made positive. A zero numerator comes back
// unreduced with the cross-product denominator; a zero denominator sets m_tuser and
// returns the unreduced numerator over zero. Items are handled one at a time: the next
// beat is taken as soon as the previous result has moved into the output register, even
// if that result is still waiting on m_tready. Zero cases go straight to the output stage;
// the others strip the T common factors of two, run the bit-serial binary GCD and divide
// numerator and denominator by it on the shared one-bit-per-cycle divider, whose internal
// width is P = min(2*W+1, 64), 33 at 16-bit operands.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    // a_num, a_den, b_num, b_den
    input  logic [((4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0]  s_tdata,
    // action
    input  logic [rau_pkg::ACT_W-1:0]                       s_tuser,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    // res_num, res_den, zero pad
    output logic [rau_pkg::OUT_DW-1:0]                      m_tdata,
    // status
    output logic [0:0]                                      m_tuser
);

    localparam int W = OPERAND_WIDTH;

    rau_pkg::dp_cmd_t                 cmd;
    rau_pkg::dp_stat_t                stat;
    logic signed [rau_pkg::RES_W-1:0] res_num;
    logic signed [rau_pkg::RES_W-1:0] res_den;
    logic                             res_status;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rau_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .stat       (stat),
        .in_action  (s_tuser),
        .in_a_num   (signed'(s_tdata[W-1:0])),
        .in_a_den   (signed'(s_tdata[2*W-1:W])),
        .in_b_num   (signed'(s_tdata[3*W-1:2*W])),
        .in_b_den   (signed'(s_tdata[4*W-1:3*W])),
        .res_num    (res_num),
        .res_den    (res_den),
        .res_status (res_status)
    );

    assign m_tdata = rau_pkg::OUT_DW'({res_den, res_num});
    assign m_tuser = res_status;

endmodule

// ===== rtl/core/rau_dp.sv =====
module rau_dp #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                    clk,
    input  rau_pkg::dp_cmd_t                        cmd,
    output rau_pkg::dp_stat_t                       stat,
    input  logic [rau_pkg::ACT_W-1:0]               in_action,
    input  logic signed [OPERAND_WIDTH-1:0]         in_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]         in_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]         in_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]         in_b_den,
    output logic signed [rau_pkg::RES_W-1:0]        res_num,
    output logic signed [rau_pkg::RES_W-1:0]        res_den,
    output logic                                    res_status
);

    localparam int W   = OPERAND_WIDTH;
    localparam int PW  = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
    localparam int KW  = $clog2(PW);
    localparam int CW  = $clog2(PW + 1);
    localparam int RW  = rau_pkg::RES_W;
    localparam int EXT = (PW > RW) ? PW : RW;

    logic [rau_pkg::ACT_W-1:0] action_reg, action_next;
    logic signed [W-1:0]       an_reg, an_next, ad_reg, ad_next;
    logic signed [W-1:0]       bn_reg, bn_next, bd_reg, bd_next;
    logic signed [2*W-1:0]     prod_reg, prod_next;
    logic signed [PW-1:0]      num_reg, num_next, den_reg, den_next;
    logic [PW-1:0]             u_reg, u_next, v_reg, v_next;
    logic [KW-1:0]             k_reg, k_next;
    logic [PW-1:0]             rem_reg, rem_next, quo_reg, quo_next, qn_reg, qn_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic signed [RW-1:0]      res_num_reg, res_num_next, res_den_reg, res_den_next;
    logic                      status_reg, status_next;

    logic signed [W-1:0]       mul_x, mul_y;
    logic signed [2*W-1:0]     prod;
    logic signed [PW-1:0]      prod_ext;
    logic [PW-1:0]             num_mag, den_mag;
    logic [PW:0]               trial, diff;
    logic                      q_bit;
    logic [EXT-1:0]            qn_ext, qd_ext, red_num;
    logic signed [EXT-1:0]     num_sx, den_sx;

    // multiplier operand selection
    always_comb
    begin
        mul_x = an_reg;
        mul_y = bd_reg;
        case (cmd.op)
            rau_pkg::OP_MUL_A:
            begin
                mul_x = an_reg;
                mul_y = (action_reg == rau_pkg::ACT_MUL) ? bn_reg : bd_reg;
            end
            rau_pkg::OP_MUL_B:
            begin
                mul_x = bn_reg;
                mul_y = ad_reg;
            end
            rau_pkg::OP_MUL_C:
            begin
                mul_x = ad_reg;
                mul_y = (action_reg == rau_pkg::ACT_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mul_x = an_reg;
                mul_y = bd_reg;
            end
        endcase
    end

    assign prod     = (2*W)'(mul_x) * (2*W)'(mul_y);
    assign prod_ext = PW'(prod_reg);
    assign num_mag  = num_reg[PW-1] ? unsigned'(-num_reg) : unsigned'(num_reg);
    assign den_mag  = den_reg[PW-1] ? unsigned'(-den_reg) : unsigned'(den_reg);

    // restoring divider step
    assign trial = {rem_reg, quo_reg[PW-1]};
    assign diff  = trial - {1'b0, u_reg};
    assign q_bit = !diff[PW];

    // sign fix-up of the reduced result
    assign qn_ext  = EXT'(qn_reg);
    assign qd_ext  = EXT'(quo_reg);
    assign red_num = (num_reg[PW-1] ^ den_reg[PW-1]) ? (-qn_ext) : qn_ext;
    assign num_sx  = EXT'(num_reg);
    assign den_sx  = EXT'(den_reg);

    always_comb
    begin
        action_next  = action_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        prod_next    = prod_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        k_next       = k_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        qn_next      = qn_reg;
        cnt_next     = cnt_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        status_next  = status_reg;

        if (cmd.capture)
        begin
            action_next = in_action;
            an_next     = in_a_num;
            ad_next     = in_a_den;
            bn_next     = in_b_num;
            bd_next     = in_b_den;
        end

        case (cmd.op)
            rau_pkg::OP_MUL_A:
            begin
                prod_next = prod;
            end
            rau_pkg::OP_MUL_B:
            begin
                prod_next = prod;
                num_next  = prod_ext;
            end
            rau_pkg::OP_MUL_C:
            begin
                prod_next = prod;
                if (action_reg == rau_pkg::ACT_ADD)
                begin
                    num_next = num_reg + prod_ext;
                end
                else if (action_reg == rau_pkg::ACT_SUB)
                begin
                    num_next = num_reg - prod_ext;
                end
            end
            rau_pkg::OP_DEN:
            begin
                den_next = prod_ext;
            end
            rau_pkg::OP_GCD_INIT:
            begin
                u_next = den_mag;
                v_next = num_mag;
                k_next = '0;
            end
            rau_pkg::OP_TWOS:
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            rau_pkg::OP_MAKE_ODD:
            begin
                if (!u_reg[0])
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            rau_pkg::OP_GCD_STEP:
            begin
                if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_reg > v_reg)
                begin
                    u_next = v_reg;
                    v_next = u_reg - v_reg;
                end
                else
                begin
                    v_next = v_reg - u_reg;
                end
            end
            rau_pkg::OP_DIV_N_INIT:
            begin
                quo_next = num_mag >> k_reg;
                rem_next = '0;
                cnt_next = CW'(PW);
            end
            rau_pkg::OP_DIV_STEP:
            begin
                rem_next = q_bit ? diff[PW-1:0] : trial[PW-1:0];
                quo_next = {quo_reg[PW-2:0], q_bit};
                cnt_next = cnt_reg - 1'b1;
            end
            rau_pkg::OP_DIV_D_INIT:
            begin
                qn_next  = quo_reg;
                quo_next = den_mag >> k_reg;
                rem_next = '0;
                cnt_next = CW'(PW);
            end
            default:
            begin
            end
        endcase

        if (cmd.load_out)
        begin
            if (den_reg == '0)
            begin
                res_num_next = num_sx[RW-1:0];
                res_den_next = '0;
                status_next  = 1'b1;
            end
            else if (num_reg == '0)
            begin
                res_num_next = '0;
                res_den_next = den_sx[RW-1:0];
                status_next  = 1'b0;
            end
            else
            begin
                res_num_next = red_num[RW-1:0];
                res_den_next = qd_ext[RW-1:0];
                status_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        prod_reg    <= prod_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        k_reg       <= k_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        qn_reg      <= qn_next;
        cnt_reg     <= cnt_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        status_reg  <= status_next;
    end

    assign stat.den_zero  = (den_reg == '0);
    assign stat.num_zero  = (num_reg == '0);
    assign stat.both_even = !u_reg[0] && !v_reg[0];
    assign stat.v_zero    = (v_reg == '0);
    assign stat.div_done  = (cnt_reg == '0);

    assign res_num    = res_num_reg;
    assign res_den    = res_den_reg;
    assign res_status = status_reg;

endmodule

// ===== rtl/core/rau_ctrl.sv =====
`include "rational_arithmetic_unit_macros.svh"

module rau_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output rau_pkg::dp_cmd_t   cmd,
    input  rau_pkg::dp_stat_t  stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL_A = 4'd1;
    localparam logic [3:0] S_MUL_B = 4'd2;
    localparam logic [3:0] S_MUL_C = 4'd3;
    localparam logic [3:0] S_DEN   = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_TWOS  = 4'd6;
    localparam logic [3:0] S_GCD   = 4'd7;
    localparam logic [3:0] S_DIV_N = 4'd8;
    localparam logic [3:0] S_DIV_D = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.op       = rau_pkg::OP_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                cmd.op     = rau_pkg::OP_MUL_A;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.op     = rau_pkg::OP_MUL_B;
                state_next = S_MUL_C;
            end
            S_MUL_C:
            begin
                cmd.op     = rau_pkg::OP_MUL_C;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                cmd.op     = rau_pkg::OP_DEN;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.op     = rau_pkg::OP_GCD_INIT;
                state_next = (stat.den_zero || stat.num_zero) ? S_OUT : S_TWOS;
            end
            S_TWOS:
            begin
                if (stat.both_even)
                begin
                    cmd.op = rau_pkg::OP_TWOS;
                end
                else
                begin
                    cmd.op     = rau_pkg::OP_MAKE_ODD;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (stat.v_zero)
                begin
                    cmd.op     = rau_pkg::OP_DIV_N_INIT;
                    state_next = S_DIV_N;
                end
                else
                begin
                    cmd.op = rau_pkg::OP_GCD_STEP;
                end
            end
            S_DIV_N:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = rau_pkg::OP_DIV_D_INIT;
                    state_next = S_DIV_D;
                end
                else
                begin
                    cmd.op = rau_pkg::OP_DIV_STEP;
                end
            end
            S_DIV_D:
            begin
                if (stat.div_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op = rau_pkg::OP_DIV_STEP;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `RAU_ASSERT_IMP(a_out_free, cmd.load_out, !m_tvalid_reg || m_tready)
    `RAU_ASSERT_NEXT(a_cap_start, cmd.capture, state_reg == S_MUL_A)
    `RAU_ASSERT_IMP(a_div_live, cmd.op == rau_pkg::OP_DIV_STEP, !stat.div_done)
    `RAU_ASSERT_NEXT(a_zero_skip, state_reg == S_CHECK && stat.den_zero, state_reg == S_OUT)

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    localparam int ACT_W     = rau_pkg::ACT_W;
    localparam int RES_W     = rau_pkg::RES_W;
    localparam int OUT_DW    = rau_pkg::OUT_DW;
    localparam int OPW       = 16;
    localparam int IN_DW     = ((4 * OPW + 7) / 8) * 8;
    localparam int RANDOM_N  = 1630;
    localparam int CALM_TAIL = 150;
    localparam int LONG_HOLD = 600;
    localparam int LIMIT     = 3000000;

    typedef struct {
        logic [ACT_W-1:0]      action;
        logic signed [OPW-1:0] a_num;
        logic signed [OPW-1:0] a_den;
        logic signed [OPW-1:0] b_num;
        logic signed [OPW-1:0] b_den;
        bit                    drain;
    } fraction_job_t;

    typedef struct {
        logic [RES_W-1:0] res_num;
        logic [RES_W-1:0] res_den;
        logic             status;
    } reduced_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata = '0;
    logic [ACT_W-1:0]  s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic [0:0]        m_tuser;

    fraction_job_t fraction_jobs[$];
    reduced_t      reduced_results[$];
    fraction_job_t cur_job;
    int            send_gap = 0;
    int            stall_cnt = 0;
    int            hold_cnt = 0;
    bit            long_hold_done = 1'b0;
    int            results_seen = 0;
    int            errors = 0;
    int            cycle_count = 0;

    rational_arithmetic_unit #(
        .OPERAND_WIDTH(OPW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // cross products, then euclidean reduction and sign fix of the denominator
    function automatic reduced_t predict_reduced(input fraction_job_t job);
        longint   an;
        longint   ad;
        longint   bn;
        longint   bd;
        longint   n;
        longint   d;
        longint   x;
        longint   y;
        longint   r;
        longint   nm;
        longint   dm;
        reduced_t q;
        an = job.a_num;
        ad = job.a_den;
        bn = job.b_num;
        bd = job.b_den;
        n  = 0;
        d  = 0;
        case (job.action)
            rau_pkg::ACT_ADD:
            begin
                n = an * bd + bn * ad;
                d = ad * bd;
            end
            rau_pkg::ACT_SUB:
            begin
                n = an * bd - bn * ad;
                d = ad * bd;
            end
            rau_pkg::ACT_MUL:
            begin
                n = an * bn;
                d = ad * bd;
            end
            rau_pkg::ACT_DIV:
            begin
                n = an * bd;
                d = ad * bn;
            end
            default:
            begin
                n = 0;
                d = 0;
            end
        endcase
        q.status = 1'b0;
        if (d == 0)
        begin
            q.status = 1'b1;
        end
        else if (n != 0)
        begin
            x = abs64(d);
            y = abs64(n);
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            nm = abs64(n) / x;
            dm = abs64(d) / x;
            n  = (n < 0) ? -nm : nm;
            d  = (d < 0) ? -dm : dm;
            if (d < 0)
            begin
                n = -n;
                d = -d;
            end
        end
        q.res_num = n[RES_W-1:0];
        q.res_den = d[RES_W-1:0];
        return q;
    endfunction

    task automatic add_job(input logic [ACT_W-1:0] action, input int an, input int ad,
                           input int bn, input int bd, input bit drain);
        fraction_job_t job;
        job.action = action;
        job.a_num  = an[OPW-1:0];
        job.a_den  = ad[OPW-1:0];
        job.b_num  = bn[OPW-1:0];
        job.b_den  = bd[OPW-1:0];
        job.drain  = drain;
        fraction_jobs = {fraction_jobs, job};
    endtask

    function automatic int pick_operand();
        int unsigned sel;
        int          corners[6];
        corners = '{-32768, -32767, -1, 0, 1, 32767};
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return int'($urandom_range(0, 65535)) - 32768;
        else if (sel < 7)
            return int'($urandom_range(0, 32)) - 16;
        else if (sel == 7)
            return corners[$urandom_range(0, 5)];
        else if (sel == 8)
            return (int'($urandom_range(0, 16)) - 8) <<< $urandom_range(0, 11);
        else
            return 0;
    endfunction

    // driver
    always @(posedge clk)
    begin
        fraction_job_t head;
        logic          fire;
        logic          offer;
        fire  = s_tvalid && s_tready;
        if (fire)
            reduced_results = {reduced_results, predict_reduced(cur_job)};
        offer = s_tvalid && !fire;
        if (!offer && rst_n)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
            end
            else if (fraction_jobs.size() != 0)
            begin
                head = fraction_jobs[0];
                if (!head.drain || reduced_results.size() == 0)
                begin
                    void'(fraction_jobs.pop_front());
                    cur_job <= head;
                    s_tdata <= {head.b_den, head.b_num, head.a_den, head.a_num};
                    s_tuser <= head.action;
                    offer = 1'b1;
                    if (fraction_jobs.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 8);
                end
            end
        end
        s_tvalid <= offer;
    end

    // monitor and checker
    always @(posedge clk)
    begin
        reduced_t exp_r;
        reduced_t got;
        logic     ready_next;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.res_num = m_tdata[RES_W-1:0];
                got.res_den = m_tdata[2*RES_W-1:RES_W];
                got.status  = m_tuser[0];
                results_seen++;
                if (reduced_results.size() == 0)
                begin
                    $error("result beat with nothing outstanding: res_num %0d res_den %0d",
                           $signed(got.res_num), $signed(got.res_den));
                    errors++;
                end
                else
                begin
                    exp_r = reduced_results.pop_front();
                    if (got.res_num !== exp_r.res_num)
                    begin
                        $error("res_num expected %0d got %0d",
                               $signed(exp_r.res_num), $signed(got.res_num));
                        errors++;
                    end
                    if (got.res_den !== exp_r.res_den)
                    begin
                        $error("res_den expected %0d got %0d",
                               $signed(exp_r.res_den), $signed(got.res_den));
                        errors++;
                    end
                    if (got.status !== exp_r.status)
                    begin
                        $error("status expected %0d got %0d", exp_r.status, got.status);
                        errors++;
                    end
                end
            end
            ready_next = 1'b1;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                ready_next = 1'b0;
            end
            else if (!long_hold_done && results_seen == 100)
            begin
                // long back-pressure so the input side fills and stalls
                hold_cnt       = LONG_HOLD;
                long_hold_done = 1'b1;
                ready_next     = 1'b0;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt--;
                ready_next = 1'b0;
            end
            else if (fraction_jobs.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
            begin
                stall_cnt  = $urandom_range(0, 7);
                ready_next = 1'b0;
            end
            m_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("[rational_arithmetic_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        add_job(rau_pkg::ACT_ADD, 1, 2, 1, 3, 0);
        add_job(rau_pkg::ACT_SUB, 1, 2, 1, 2, 0);
        add_job(rau_pkg::ACT_MUL, -32768, -32768, -32768, -32768, 0);
        add_job(rau_pkg::ACT_DIV, 32767, -32768, -32768, 32767, 0);
        add_job(rau_pkg::ACT_ADD, -32768, -32768, -32768, -32768, 0);
        add_job(rau_pkg::ACT_SUB, 32767, -32768, -32768, 32767, 0);
        add_job(rau_pkg::ACT_ADD, 5, 0, 3, 7, 0);
        add_job(rau_pkg::ACT_DIV, 6, 4, 0, 9, 0);
        add_job(rau_pkg::ACT_MUL, 0, -3, 5, 7, 0);
        add_job(rau_pkg::ACT_DIV, 0, 5, -2, 3, 0);
        add_job(rau_pkg::ACT_ADD, 0, 0, 0, 0, 0);
        add_job(rau_pkg::ACT_SUB, 0, 0, 0, 0, 0);
        add_job(rau_pkg::ACT_MUL, 0, 0, 0, 0, 0);
        add_job(rau_pkg::ACT_DIV, 0, 0, 0, 0, 0);
        add_job(rau_pkg::ACT_MUL, 3, -4, 1, 1, 0);
        add_job(rau_pkg::ACT_DIV, -1, -1, -1, -1, 0);
        add_job(rau_pkg::ACT_SUB, -1, 32767, 1, -32768, 0);
        add_job(rau_pkg::ACT_MUL, 32767, 32767, 32767, 32767, 0);
        add_job(rau_pkg::ACT_ADD, 1024, -2048, 4096, 512, 0);
        add_job(rau_pkg::ACT_DIV, -32768, 1, 1, -32768, 0);
        for (int i = 0; i < RANDOM_N; i++)
            add_job(ACT_W'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                    pick_operand(), pick_operand(), (i == 0) || (i == RANDOM_N / 2));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (fraction_jobs.size() != 0 || s_tvalid)
            @(posedge clk);
        while (reduced_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0 && reduced_results.size() == 0)
            $display("[rational_arithmetic_unit] OK");
        else
            $display("[rational_arithmetic_unit] ERROR");
        $finish;
    end

endmodule
